@@ rtl/cslm_pkg.sv @@
// Package for the circular row-shift minimum L1 distance block.
// Holds sizes, configuration register indexes and transaction types.
// No dependencies.
package cslm_pkg;

  // Grid capacity and value format
  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 64;
  localparam int VALUE_BITS  = 16;
  localparam int GRID_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = $clog2(GRID_DEPTH);
  localparam int BASE_W      = ADDR_W + 1;

  // Field and register widths
  localparam int ROWS_W      = 4;
  localparam int COLS_W      = 7;
  localparam int NEED_W      = ROWS_W + COLS_W;
  localparam int CNT_W       = 10;
  localparam int DIST_W      = 25;
  localparam int SHIFT_W     = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = '1;

  // Reset values of the configuration registers
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(8);
  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(50);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

  typedef struct packed {
    logic [VALUE_BITS-1:0] first_value;
    logic [VALUE_BITS-1:0] second_value;
    logic                  last_pair;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]  min_distance;
    logic [SHIFT_W-1:0] best_shift;
    logic               count_mismatch;
  } out_item_t;

  // Write port of the grid memories
  typedef struct packed {
    logic                  en;
    logic [ADDR_W-1:0]     addr;
    logic [VALUE_BITS-1:0] first_value;
    logic [VALUE_BITS-1:0] second_value;
  } grid_wr_t;

  // Read addresses into the two grids
  typedef struct packed {
    logic [ADDR_W-1:0] addr_first;
    logic [ADDR_W-1:0] addr_second;
  } grid_rd_t;

  // Result of one full comparison
  typedef struct packed {
    logic               done;
    logic [DIST_W-1:0]  min_distance;
    logic [SHIFT_W-1:0] best_shift;
  } scan_res_t;

endpackage

@@ rtl/cslm_grid_mem.sv @@
// Grid storage: one memory per grid, one write and one registered read each.
// Depends on cslm_pkg.
module cslm_grid_mem
  import cslm_pkg::*;
(
  input  logic                  clk,
  input  grid_wr_t              wr,
  input  grid_rd_t              rd,
  output logic [VALUE_BITS-1:0] first_rdata,
  output logic [VALUE_BITS-1:0] second_rdata
);

  logic [VALUE_BITS-1:0] first_mem  [GRID_DEPTH];
  logic [VALUE_BITS-1:0] second_mem [GRID_DEPTH];

  // Write port, shared address
  always_ff @(posedge clk) begin
    if (wr.en) begin
      first_mem[wr.addr]  <= wr.first_value;
      second_mem[wr.addr] <= wr.second_value;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    first_rdata  <= first_mem[rd.addr_first];
    second_rdata <= second_mem[rd.addr_second];
  end

endmodule

@@ rtl/cslm_scan.sv @@
// Comparison sequencer: walks every shift, row and column through the grid
// memories, accumulates |a - b| per shift and keeps the smallest sum.
// Depends on cslm_pkg.
module cslm_scan
  import cslm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [ROWS_W-1:0]     rows,
  input  logic [COLS_W-1:0]     cols,
  output grid_rd_t              rd,
  input  logic [VALUE_BITS-1:0] first_rdata,
  input  logic [VALUE_BITS-1:0] second_rdata,
  output scan_res_t             res
);

  logic [ROWS_W-1:0] rows_m1;
  logic [COLS_W-1:0] cols_m1;

  // Address generation counters
  logic              running_r, running_nxt;
  logic [ROWS_W-1:0] shift_r, shift_nxt;
  logic [ROWS_W-1:0] row_r, row_nxt;
  logic [ROWS_W-1:0] rs_r, rs_nxt;
  logic [COLS_W-1:0] col_r, col_nxt;
  logic [BASE_W-1:0] base_a_r, base_a_nxt;
  logic [BASE_W-1:0] base_b_r, base_b_nxt;
  logic [BASE_W-1:0] shift_base_r, shift_base_nxt;
  logic [BASE_W-1:0] addr_a, addr_b;

  logic col_end, row_end, shift_end;

  // Pipeline tags
  logic               v1_r, first1_r, last1_r, final1_r;
  logic [SHIFT_W-1:0] sh1_r;
  logic               v2_r, first2_r, last2_r, final2_r;
  logic [SHIFT_W-1:0] sh2_r;
  logic [VALUE_BITS-1:0] diff_r;
  logic               v3_r, final3_r;
  logic [SHIFT_W-1:0] sh3_r;
  logic [DIST_W-1:0]  acc_r;
  logic [DIST_W-1:0]  best_r;
  logic [SHIFT_W-1:0] best_shift_r;
  logic               take_new;

  assign rows_m1 = rows - ROWS_W'(1);
  assign cols_m1 = cols - COLS_W'(1);

  assign col_end   = (col_r == cols_m1);
  assign row_end   = (row_r == rows_m1);
  assign shift_end = (shift_r == rows_m1);

  assign addr_a = base_a_r + BASE_W'(col_r);
  assign addr_b = base_b_r + BASE_W'(col_r);
  assign rd.addr_first  = addr_a[ADDR_W-1:0];
  assign rd.addr_second = addr_b[ADDR_W-1:0];

  // Counter stepping: column, then row (with wrapped second row), then shift
  always_comb begin
    running_nxt    = running_r;
    shift_nxt      = shift_r;
    row_nxt        = row_r;
    rs_nxt         = rs_r;
    col_nxt        = col_r;
    base_a_nxt     = base_a_r;
    base_b_nxt     = base_b_r;
    shift_base_nxt = shift_base_r;
    if (go) begin
      running_nxt    = 1'b1;
      shift_nxt      = '0;
      row_nxt        = '0;
      rs_nxt         = '0;
      col_nxt        = '0;
      base_a_nxt     = '0;
      base_b_nxt     = '0;
      shift_base_nxt = '0;
    end else if (running_r) begin
      if (!col_end) begin
        col_nxt = col_r + COLS_W'(1);
      end else begin
        col_nxt = '0;
        if (row_end) begin
          if (shift_end) begin
            running_nxt = 1'b0;
          end
          row_nxt        = '0;
          base_a_nxt     = '0;
          shift_nxt      = shift_r + ROWS_W'(1);
          shift_base_nxt = shift_base_r + BASE_W'(cols);
          rs_nxt         = shift_r + ROWS_W'(1);
          base_b_nxt     = shift_base_r + BASE_W'(cols);
        end else begin
          row_nxt    = row_r + ROWS_W'(1);
          base_a_nxt = base_a_r + BASE_W'(cols);
          if (rs_r == rows_m1) begin
            rs_nxt     = '0;
            base_b_nxt = '0;
          end else begin
            rs_nxt     = rs_r + ROWS_W'(1);
            base_b_nxt = base_b_r + BASE_W'(cols);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else begin
      running_r <= running_nxt;
    end
    shift_r      <= shift_nxt;
    row_r        <= row_nxt;
    rs_r         <= rs_nxt;
    col_r        <= col_nxt;
    base_a_r     <= base_a_nxt;
    base_b_r     <= base_b_nxt;
    shift_base_r <= shift_base_nxt;
  end

  // Tags are registered alongside the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= running_r;
      v2_r <= v1_r;
      v3_r <= v2_r & last2_r;
    end
    first1_r <= (row_r == '0) && (col_r == '0);
    last1_r  <= row_end & col_end;
    final1_r <= row_end & col_end & shift_end;
    sh1_r    <= shift_r[SHIFT_W-1:0];
    first2_r <= first1_r;
    last2_r  <= last1_r;
    final2_r <= final1_r;
    sh2_r    <= sh1_r;
    final3_r <= final2_r;
    sh3_r    <= sh2_r;
  end

  // Absolute difference
  always_ff @(posedge clk) begin
    diff_r <= (first_rdata > second_rdata) ? (first_rdata - second_rdata)
                                           : (second_rdata - first_rdata);
  end

  // Per-shift accumulator
  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= first2_r ? DIST_W'(diff_r) : acc_r + DIST_W'(diff_r);
    end
  end

  // Keep the first shift with the smallest sum
  assign take_new = (sh3_r == '0) || (acc_r < best_r);

  always_ff @(posedge clk) begin
    if (v3_r && take_new) begin
      best_r       <= acc_r;
      best_shift_r <= sh3_r;
    end
  end

  assign res.done         = v3_r & final3_r;
  assign res.min_distance = take_new ? acc_r : best_r;
  assign res.best_shift   = take_new ? sh3_r : best_shift_r;

endmodule

@@ rtl/circular_shift_min_l1_distance.sv @@
// Top level: configuration registers, pair counter, grid memories and
// comparison sequencer. Depends on cslm_pkg, cslm_grid_mem, cslm_scan.
//
//  channel | ports                          | transaction
//  --------+--------------------------------+-----------------------------------
//  input   | start, busy, in_item           | start high while busy low
//  result  | out_valid, out_item            | out_valid high for one cycle
//  config  | cfg_we, cfg_idx, cfg_wdata     | cfg_we high at the clock edge
//
// Element pairs load at one per cycle while busy is low. A last pair with a
// wrong count gives its result in the next cycle. Otherwise busy rises and
// stays high while one difference per cycle goes through the single read
// port of each grid memory; the result shows in the first cycle with busy low.
// rst_n is synchronous; the grids hold no reset. The receiver cannot stall.
module circular_shift_min_l1_distance
  import cslm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [ROWS_W-1:0] grid_rows_r;
  logic [COLS_W-1:0] grid_cols_r;
  logic [ROWS_W-1:0] rows_eff;
  logic [COLS_W-1:0] cols_eff;
  logic [NEED_W-1:0] need;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              accept;
  logic              mismatch;
  logic              scan_go;
  grid_wr_t          wr;
  grid_rd_t          rd;
  logic [VALUE_BITS-1:0] first_rdata, second_rdata;
  scan_res_t         res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= ROWS_RESET;
      grid_cols_r <= COLS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GRID_ROWS: grid_rows_r <= cfg_wdata[ROWS_W-1:0];
        CFG_GRID_COLS: grid_cols_r <= cfg_wdata[COLS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp to the grid capacity; a zero size counts as one
  always_comb begin
    if (grid_rows_r == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (grid_rows_r > ROWS_W'(MAX_ROWS)) begin
      rows_eff = ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = grid_rows_r;
    end
    if (grid_cols_r == '0) begin
      cols_eff = COLS_W'(1);
    end else if (grid_cols_r > COLS_W'(MAX_COLS)) begin
      cols_eff = COLS_W'(MAX_COLS);
    end else begin
      cols_eff = grid_cols_r;
    end
  end

  assign need = NEED_W'(rows_eff) * NEED_W'(cols_eff);

  assign accept   = start & ~busy_r;
  assign cnt_inc  = (cnt_r != COUNT_LIMIT) ? cnt_r + CNT_W'(1) : cnt_r;
  assign mismatch = (NEED_W'(cnt_inc) != need);
  assign scan_go  = accept & in_item.last_pair & ~mismatch;

  // Memory write of each accepted pair while it fits
  assign wr.en           = accept && (cnt_r < CNT_W'(GRID_DEPTH));
  assign wr.addr         = cnt_r[ADDR_W-1:0];
  assign wr.first_value  = in_item.first_value;
  assign wr.second_value = in_item.second_value;

  // Pair count, busy flag and result register
  always_comb begin
    cnt_nxt       = cnt_r;
    busy_nxt      = busy_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (accept) begin
      cnt_nxt = in_item.last_pair ? '0 : cnt_inc;
      if (in_item.last_pair) begin
        if (mismatch) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.min_distance   = '0;
          out_item_nxt.best_shift     = '0;
          out_item_nxt.count_mismatch = 1'b1;
        end else begin
          busy_nxt = 1'b1;
        end
      end
    end
    if (res.done) begin
      busy_nxt                    = 1'b0;
      out_valid_nxt               = 1'b1;
      out_item_nxt.min_distance   = res.min_distance;
      out_item_nxt.best_shift     = res.best_shift;
      out_item_nxt.count_mismatch = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  cslm_grid_mem u_mem (
    .clk          (clk),
    .wr           (wr),
    .rd           (rd),
    .first_rdata  (first_rdata),
    .second_rdata (second_rdata)
  );

  cslm_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (scan_go),
    .rows         (rows_eff),
    .cols         (cols_eff),
    .rd           (rd),
    .first_rdata  (first_rdata),
    .second_rdata (second_rdata),
    .res          (res)
  );

endmodule

@@ test/circular_shift_min_l1_distance_checker.sv @@
// Checker for the circular row-shift minimum L1 distance block: follows the
// configuration writes and element pairs, predicts each result and compares.
// Depends on cslm_pkg.
module circular_shift_min_l1_distance_checker
  import cslm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending,
  output int                    fault_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned DIST_MAX = (64'd1 << DIST_W) - 1;

  // Own copy of the grids, the pair count and the registers
  logic [VALUE_BITS-1:0] first_copy  [GRID_DEPTH];
  logic [VALUE_BITS-1:0] second_copy [GRID_DEPTH];
  logic [CNT_W-1:0]      pairs_seen;
  logic [ROWS_W-1:0]     rows_reg;
  logic [COLS_W-1:0]     cols_reg;
  out_item_t             awaited_results [$];

  initial begin
    pending     = 0;
    fault_count = 0;
  end

  // Stores one pair; on the last pair works out the best rotation, or flags a count mismatch, and returns 1
  function automatic bit absorb_pair(input in_item_t item, output out_item_t res);
    int unsigned       rows, cols, need, rs, a, b, best_at;
    longint unsigned   sum, best;
    rows = (rows_reg == '0) ? 1 : (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    cols = (cols_reg == '0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : cols_reg;
    need = rows * cols;
    res  = '0;
    if (pairs_seen < GRID_DEPTH) begin
      first_copy[pairs_seen]  = item.first_value;
      second_copy[pairs_seen] = item.second_value;
    end
    if (pairs_seen != COUNT_LIMIT) pairs_seen++;
    if (!item.last_pair) return 1'b0;
    if (pairs_seen != need) begin
      res.count_mismatch = 1'b1;
      pairs_seen = '0;
      return 1'b1;
    end
    best    = 0;
    best_at = 0;
    for (int s = 0; s < rows; s++) begin
      sum = 0;
      for (int r = 0; r < rows; r++) begin
        rs = (r + s) % rows;
        for (int c = 0; c < cols; c++) begin
          a = first_copy[r * cols + c];
          b = second_copy[rs * cols + c];
          sum += (a > b) ? a - b : b - a;
        end
      end
      // a later shift only wins when strictly smaller
      if (s == 0 || sum < best) begin
        best    = sum;
        best_at = s;
      end
    end
    res.min_distance = (best > DIST_MAX) ? '1 : DIST_W'(best);
    res.best_shift   = SHIFT_W'(best_at);
    pairs_seen = '0;
    return 1'b1;
  endfunction

  // Values sampled are those before the edge, so order within the step is moot
  always @(posedge clk) begin
    out_item_t predicted;
    out_item_t wanted;
    if (!rst_n) begin
      pairs_seen = '0;
      rows_reg   = ROWS_RESET;
      cols_reg   = COLS_RESET;
      awaited_results.delete();
    end else begin
      // a result here always belongs to an earlier transaction
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: min_distance %0d best_shift %0d count_mismatch %0d",
                 out_item.min_distance, out_item.best_shift, out_item.count_mismatch);
          fault_count++;
        end else begin
          wanted = awaited_results.pop_front();
          if (out_item.min_distance !== wanted.min_distance) begin
            $error("min_distance: expected %0d, got %0d",
                   wanted.min_distance, out_item.min_distance);
            fault_count++;
          end
          if (out_item.best_shift !== wanted.best_shift) begin
            $error("best_shift: expected %0d, got %0d",
                   wanted.best_shift, out_item.best_shift);
            fault_count++;
          end
          if (out_item.count_mismatch !== wanted.count_mismatch) begin
            $error("count_mismatch: expected %0d, got %0d",
                   wanted.count_mismatch, out_item.count_mismatch);
            fault_count++;
          end
        end
      end
      // a pair taken at this edge still sees the registers from before it
      if (start && !busy) begin
        if (absorb_pair(in_item, predicted)) begin
          awaited_results.insert(awaited_results.size(), predicted);
        end
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_GRID_ROWS) rows_reg = cfg_wdata[ROWS_W-1:0];
        else if (cfg_idx == CFG_GRID_COLS) cols_reg = cfg_wdata[COLS_W-1:0];
      end
    end
    pending <= awaited_results.size();
  end

endmodule

@@ test/circular_shift_min_l1_distance_test.sv @@
// Testbench top for circular_shift_min_l1_distance: clock, reset, stimulus
// and verdict. Depends on cslm_pkg, the block and its checker module.
module circular_shift_min_l1_distance_test;
  import cslm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_PAIRS  = 380;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 20000;
  localparam logic [VALUE_BITS-1:0] FULL_SCALE = '1;

  // How a load's grid contents are made up
  typedef enum int {
    FILL_RANDOM,
    FILL_TINY,
    FILL_RAILS,
    FILL_ROTATED,
    FILL_NEAR_ROTATED
  } fill_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    pending;
  int                    fault_count;

  // Sizes in effect after the latest configuration
  int unsigned           rows_used;
  int unsigned           cols_used;
  logic [VALUE_BITS-1:0] first_plan  [GRID_DEPTH];
  logic [VALUE_BITS-1:0] second_plan [GRID_DEPTH];

  circular_shift_min_l1_distance dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  circular_shift_min_l1_distance_checker distance_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .pending     (pending),
    .fault_count (fault_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic in_item_t pack_pair(input logic [VALUE_BITS-1:0] first_v,
                                         input logic [VALUE_BITS-1:0] second_v,
                                         input logic                  last_v);
    in_item_t item;
    item.first_value  = first_v;
    item.second_value = second_v;
    item.last_pair    = last_v;
    return item;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int unsigned draw_gap(input bit burst);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (burst || pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [VALUE_BITS-1:0] draw_value(input fill_t fill);
    case (fill)
      FILL_TINY:  return VALUE_BITS'($urandom_range(0, 3));
      FILL_RAILS: return $urandom_range(0, 1) ? FULL_SCALE : '0;
      default:    return VALUE_BITS'($urandom);
    endcase
  endfunction

  // One transaction; start stays high when no gap follows
  task automatic send_pair(input in_item_t item, input int unsigned gap);
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every awaited result is in, then let the block settle
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input int unsigned rows_val, input int unsigned cols_val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_GRID_ROWS;
    // spare data bits above the rows field are junk on purpose
    cfg_wdata <= {(CFG_DATA_W-ROWS_W)'($urandom), ROWS_W'(rows_val)};
    @(posedge clk);
    cfg_idx   <= CFG_GRID_COLS;
    cfg_wdata <= CFG_DATA_W'(cols_val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_used = (rows_val == 0) ? 1 : (rows_val > MAX_ROWS) ? MAX_ROWS : rows_val;
    cols_used = (cols_val == 0) ? 1 : (cols_val > MAX_COLS) ? MAX_COLS : cols_val;
  endtask

  // Streams a load of the given length, last pair marked on the final one
  task automatic send_load(input int unsigned pairs, input fill_t fill, input bit burst);
    int unsigned rot, idx;
    logic [VALUE_BITS-1:0] first_v, second_v;
    rot = $urandom_range(0, rows_used - 1);
    for (int i = 0; i < GRID_DEPTH; i++) begin
      first_plan[i]  = draw_value(fill);
      second_plan[i] = draw_value(fill);
    end
    // second grid is the first with its rows rotated, so one shift gives zero for FILL_ROTATED
    if (fill == FILL_ROTATED || fill == FILL_NEAR_ROTATED) begin
      for (int r = 0; r < rows_used; r++)
        for (int c = 0; c < cols_used; c++)
          second_plan[((r + rot) % rows_used) * cols_used + c] = first_plan[r * cols_used + c];
      if (fill == FILL_NEAR_ROTATED) begin
        repeat (3) begin
          idx = $urandom_range(0, rows_used * cols_used - 1);
          second_plan[idx] = second_plan[idx] ^ VALUE_BITS'($urandom_range(1, 3));
        end
      end
    end
    for (int i = 0; i < pairs; i++) begin
      first_v  = (i < GRID_DEPTH) ? first_plan[i]  : VALUE_BITS'($urandom);
      second_v = (i < GRID_DEPTH) ? second_plan[i] : VALUE_BITS'($urandom);
      send_pair(pack_pair(first_v, second_v, i == pairs - 1), draw_gap(burst));
    end
  endtask

  // Watchdog: ends the run after too long without any transaction
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_valid || cfg_we) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent, pick, loads, need, n, form;
    bit          big;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_GRID_ROWS;
    cfg_wdata = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Single cell: full-scale differences both ways and equal values
    set_grid(1, 1);
    send_pair(pack_pair('0, FULL_SCALE, 1'b1), 1);
    send_pair(pack_pair(FULL_SCALE, '0, 1'b1), 0);
    send_pair(pack_pair(FULL_SCALE, FULL_SCALE, 1'b1), 2);

    // Zero rows and columns behave as one
    set_grid(0, 0);
    send_pair(pack_pair(16'h1234, 16'h0234, 1'b1), 0);

    // 2x2: all shifts tie so shift 0 stays; swapped rows give shift 1
    set_grid(2, 2);
    repeat (3) send_pair(pack_pair(16'h0555, 16'h0555, 1'b0), 0);
    send_pair(pack_pair(16'h0555, 16'h0555, 1'b1), 1);
    send_pair(pack_pair(16'h0100, 16'hF000, 1'b0), 0);
    send_pair(pack_pair(16'h0200, 16'h0FFF, 1'b0), 0);
    send_pair(pack_pair(16'hF000, 16'h0100, 1'b0), 0);
    send_pair(pack_pair(16'h0FFF, 16'h0200, 1'b1), 3);
    // short load, then one pair too many: both flag a count mismatch
    send_pair(pack_pair(16'h7FFF, 16'h8000, 1'b1), 0);
    send_load(5, FILL_RAILS, 1'b1);

    // Rows above the limit clamp to eight; rotated single column
    set_grid(15, 0);
    send_load(8, FILL_ROTATED, 1'b0);

    // Overlong load: the count must saturate rather than wrap back to a match
    set_grid(1, 2);
    send_load(1024 + 2, FILL_RANDOM, 1'b1);

    // Random phases, mostly small grids with the odd large one
    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      pick = $urandom_range(0, 99);
      big  = 1'b0;
      if (pick < 70) begin
        set_grid($urandom_range(1, 4), $urandom_range(1, 8));
      end else if (pick < 94) begin
        set_grid($urandom_range(0, 15), $urandom_range(0, 12));
      end else begin
        big = 1'b1;
        set_grid($urandom_range(0, 1) ? 15 : $urandom_range(5, 15),
                 $urandom_range(0, 1) ? 127 : $urandom_range(20, 127));
      end
      loads = big ? 1 : $urandom_range(3, 8);
      repeat (loads) begin
        need = rows_used * cols_used;
        form = $urandom_range(0, 99);
        if (form < 75) n = need;
        else if (form < 88 && need > 1) n = $urandom_range(1, need - 1);
        else n = need + $urandom_range(1, 6);
        send_load(n, fill_t'($urandom_range(0, 4)), $urandom_range(0, 3) == 0);
        sent += n;
      end
    end

    wait_idle();
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
